// ===== hdl/crc_checked_command_slave_defines.svh =====
// assertion macros shared by the command target modules
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef CRC_CHECKED_COMMAND_SLAVE_DEFINES_SVH
`define CRC_CHECKED_COMMAND_SLAVE_DEFINES_SVH
`ifndef SYNTHESIS
`define CCS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ccs assertion failed");
`define CCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ccs assertion failed");
`else
`define CCS_ASSERT(label, clk, rstn, prop)
`define CCS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/ccs_pkg.sv =====
// types, command codes and crc helper for the crc-checked command target
// no dependencies
package ccs_pkg;

    typedef enum logic [1:0] {
        KIND_ADDR = 2'd0,
        KIND_RX   = 2'd1,
        KIND_RD   = 2'd2,
        KIND_MEAS = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  rx_byte;
        logic [3:0]  meas_index;
        logic [15:0] meas_value;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [5:0] pin_states;
        logic [7:0] fan_duty;
        logic [7:0] led_red;
        logic [7:0] led_green;
        logic [7:0] led_blue;
        logic [7:0] backlight_target;
        logic       led_changed;
        logic       buzzer_click;
        logic [7:0] error_count;
    } result_t;

    // write commands
    localparam logic [7:0] CMD_BACKLIGHT = 8'h87;
    localparam logic [7:0] CMD_RELAY1    = 8'h8D;
    localparam logic [7:0] CMD_RELAY2    = 8'h8E;
    localparam logic [7:0] CMD_RELAY3    = 8'h8F;
    localparam logic [7:0] CMD_D13       = 8'h90;
    localparam logic [7:0] CMD_HWB       = 8'h91;
    localparam logic [7:0] CMD_BUZZER    = 8'h92;
    localparam logic [7:0] CMD_FAN       = 8'h93;
    localparam logic [7:0] CMD_RED       = 8'h94;
    localparam logic [7:0] CMD_GREEN     = 8'h95;
    localparam logic [7:0] CMD_BLUE      = 8'h96;

    // read commands
    localparam logic [7:0] CMD_RD_ANA_LAST = 8'h06;
    localparam logic [7:0] CMD_RD_BL       = 8'h07;
    localparam logic [7:0] CMD_RD_RPM      = 8'h08;
    localparam logic [7:0] CMD_RD_RAM      = 8'h0B;
    localparam logic [7:0] CMD_RD_RGB      = 8'h0C;
    localparam logic [7:0] CMD_RD_PIN1     = 8'h0D;
    localparam logic [7:0] CMD_RD_PIN6     = 8'h12;
    localparam logic [7:0] CMD_RD_FAN      = 8'h13;
    localparam logic [7:0] CMD_RD_AC       = 8'h14;

    localparam logic [3:0] SLOT_BL = 4'd7;
    localparam logic [3:0] SLOT_AC = 4'd12;

    localparam logic [7:0] NO_POS        = 8'hFF;
    localparam logic [7:0] VAL_ON        = 8'hFF;
    localparam logic [7:0] VAL_CLICK_REQ = 8'h01;
    localparam logic [7:0] VAL_CLICK     = 8'h02;
    localparam logic [7:0] BYTE_NONE     = 8'hFF;
    localparam logic [7:0] ERR_MAX       = 8'hFF;
    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam logic [7:0] FAN_RESET     = 8'd210;
    localparam logic [7:0] BL_RESET      = 8'd31;
    localparam logic [2:0] PIN_BUZZER    = 3'd5;

    // crc-8, msb first, no final xor
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // command reads a 16-bit measurement
    function automatic logic meas_slot_ok(input logic [7:0] cmd);
        return (cmd <= CMD_RD_ANA_LAST) || (cmd >= CMD_RD_RPM && cmd <= CMD_RD_RAM)
            || (cmd == CMD_RD_AC);
    endfunction

    function automatic logic [3:0] meas_slot(input logic [7:0] cmd);
        return (cmd == CMD_RD_AC) ? SLOT_AC : cmd[3:0];
    endfunction

endpackage

// ===== hdl/crc_checked_command_slave.sv =====
// top level of the crc-checked command target
// depends on ccs_pkg, ccs_meas_ram, ccs_cmd_engine and the defines header
`include "crc_checked_command_slave_defines.svh"
// Byte-level target side of a CRC-8 (poly 0x07) guarded command bus. Each input
// item is one bus event (address match, byte received, byte requested or a
// measurement update) and yields exactly one result item carrying the reply
// byte and the current pin, fan, LED, backlight and error state. The block
// takes one item per clock while the result output is not stalled by m_ready:
// an item is registered on acceptance while the measurement store is read (or,
// for an update, written) at the same edge, and the command engine consumes it
// together with the registered read data and loads the output register, which
// drives m_valid; an item waits in the pipe stage while the output is held.
// The single read port of the measurement store is used once per item. The
// store needs no clearing pass: per-entry valid bits make unwritten slots read
// as zero straight after reset. s_ready stays high while the pipe stage is
// empty or the output register is empty or being drained.
module crc_checked_command_slave #(
    parameter int MEAS_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_rx_byte,
    input  logic [3:0]  s_meas_index,
    input  logic [15:0] s_meas_value,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_tx_valid,
    output logic [5:0]  m_pin_states,
    output logic [7:0]  m_fan_duty,
    output logic [7:0]  m_led_red,
    output logic [7:0]  m_led_green,
    output logic [7:0]  m_led_blue,
    output logic [7:0]  m_backlight_target,
    output logic        m_led_changed,
    output logic        m_buzzer_click,
    output logic [7:0]  m_error_count
);

    localparam int AW = $clog2(MEAS_SLOTS);

    ccs_pkg::item_t   s_item;
    ccs_pkg::item_t   p1_item_reg;
    logic             p1_valid_reg, p1_valid_next;
    logic             accept;
    logic             eng_take;
    logic             wr_en;
    logic [AW-1:0]    rd_addr;
    logic [15:0]      rd_data;
    ccs_pkg::result_t res;

    // gather the input fields
    assign s_item.kind       = ccs_pkg::kind_t'(s_kind);
    assign s_item.rx_byte    = s_rx_byte;
    assign s_item.meas_index = s_meas_index;
    assign s_item.meas_value = s_meas_value;

    // pipe stage free when empty or when the engine takes its item this cycle
    assign s_ready = !p1_valid_reg || eng_take;
    assign accept  = s_valid && s_ready;

    // updates to slots beyond the store are dropped
    assign wr_en = accept && (s_item.kind == ccs_pkg::KIND_MEAS)
                   && ((AW + 1)'(s_meas_index) < (AW + 1)'(MEAS_SLOTS));

    // speculative read: backlight slot for a read request, else the slot the
    // byte would select if it turns out to be a command byte
    assign rd_addr = (s_item.kind == ccs_pkg::KIND_RD) ? AW'(ccs_pkg::SLOT_BL)
                                                       : AW'(ccs_pkg::meas_slot(s_rx_byte));

    ccs_meas_ram #(
        .DEPTH (MEAS_SLOTS),
        .AW    (AW)
    ) u_meas_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_meas_index)),
        .wr_data (s_meas_value),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (eng_take) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    // item payload travels beside the registered store read
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_item_reg <= s_item;
        end
    end

    ccs_cmd_engine u_cmd_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p1_valid_reg),
        .in_item   (p1_item_reg),
        .rd_data   (rd_data),
        .in_take   (eng_take),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_tx_byte          = res.tx_byte;
    assign m_tx_valid         = res.tx_valid;
    assign m_pin_states       = res.pin_states;
    assign m_fan_duty         = res.fan_duty;
    assign m_led_red          = res.led_red;
    assign m_led_green        = res.led_green;
    assign m_led_blue         = res.led_blue;
    assign m_backlight_target = res.backlight_target;
    assign m_led_changed      = res.led_changed;
    assign m_buzzer_click     = res.buzzer_click;
    assign m_error_count      = res.error_count;

    // an accepted item always lands in the pipe stage
    `CCS_ASSERT_NEXT(a_accept_lands, aclk, aresetn, accept, p1_valid_reg)
    // an empty pipe stage always takes an item
    `CCS_ASSERT(a_ready_when_empty, aclk, aresetn, !p1_valid_reg |-> s_ready)
    // a waiting item is held unchanged
    `CCS_ASSERT_NEXT(a_stall_holds, aclk, aresetn, p1_valid_reg && !eng_take, p1_valid_reg && $stable(p1_item_reg))

endmodule

// ===== hdl/ccs_meas_ram.sv =====
// measurement store: single write port, one registered read port
// entries read as zero until first written; uses no package
module ccs_meas_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0]      mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [15:0]      rd_mem_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : 16'h0000;

endmodule

// ===== hdl/ccs_cmd_engine.sv =====
// command decoder, crc check, control registers and result register
// depends on ccs_pkg and crc_checked_command_slave_defines.svh
`include "crc_checked_command_slave_defines.svh"
module ccs_cmd_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  ccs_pkg::item_t   in_item,
    input  logic [15:0]      rd_data,
    output logic             in_take,
    output logic             out_valid,
    input  logic             out_ready,
    output ccs_pkg::result_t out_res
);

    logic [7:0]  cmd_reg,   cmd_next;
    logic [7:0]  pos_reg,   pos_next;
    logic [7:0]  crc_reg,   crc_next;
    logic [7:0]  vh_reg,    vh_next;
    logic [15:0] latch_reg, latch_next;
    logic [5:0]  pin_reg,   pin_next;
    logic [7:0]  fan_reg,   fan_next;
    logic [7:0]  red_reg,   red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg,  blue_next;
    logic [7:0]  bl_reg,    bl_next;
    logic [7:0]  err_reg,   err_next;
    logic        valid_reg, valid_next;
    ccs_pkg::result_t res_reg, res_next;
    logic        cmd_start;

    assign in_take   = in_valid && (!valid_reg || out_ready);
    assign cmd_start = (in_item.kind == ccs_pkg::KIND_RX) && (pos_reg == ccs_pkg::NO_POS);

    always_comb begin
        logic       err_inc;
        logic       known;
        logic [1:0] last;
        logic [7:0] d;
        logic [7:0] tx;
        logic       led_chg;
        logic       click;

        err_inc    = 1'b0;
        known      = 1'b0;
        last       = 2'd0;
        d          = 8'h00;
        tx         = 8'h00;
        led_chg    = 1'b0;
        click      = 1'b0;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        vh_next    = vh_reg;
        latch_next = latch_reg;
        pin_next   = pin_reg;
        fan_next   = fan_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        bl_next    = bl_reg;
        err_next   = err_reg;

        if (in_take) begin
            unique case (in_item.kind)
                ccs_pkg::KIND_ADDR: begin
                    pos_next = ccs_pkg::NO_POS;
                end
                ccs_pkg::KIND_RX: begin
                    if (cmd_start) begin
                        cmd_next = in_item.rx_byte;
                        crc_next = ccs_pkg::crc_step(8'h00, in_item.rx_byte);
                        pos_next = 8'h00;
                        err_next = 8'h00;
                        if (ccs_pkg::meas_slot_ok(in_item.rx_byte)) begin
                            latch_next = rd_data;
                        end
                    end else begin
                        if (pos_reg == 8'h00) begin
                            vh_next  = in_item.rx_byte;
                            crc_next = ccs_pkg::crc_step(crc_reg, in_item.rx_byte);
                        end else if (pos_reg == 8'h01 && in_item.rx_byte == crc_reg) begin
                            // crc good: commit held value
                            unique case (cmd_reg) inside
                                ccs_pkg::CMD_BACKLIGHT: bl_next = vh_reg;
                                [ccs_pkg::CMD_RELAY1:ccs_pkg::CMD_HWB]: begin
                                    pin_next[3'(cmd_reg - ccs_pkg::CMD_RELAY1)] =
                                        (vh_reg == ccs_pkg::VAL_ON);
                                end
                                ccs_pkg::CMD_BUZZER: begin
                                    if (vh_reg == ccs_pkg::VAL_ON) begin
                                        pin_next[ccs_pkg::PIN_BUZZER] = 1'b1;
                                    end else if (vh_reg == ccs_pkg::VAL_CLICK_REQ) begin
                                        pin_next[ccs_pkg::PIN_BUZZER] = 1'b1;
                                        vh_next = ccs_pkg::VAL_CLICK;
                                    end else begin
                                        pin_next[ccs_pkg::PIN_BUZZER] = 1'b0;
                                        vh_next = 8'h00;
                                    end
                                end
                                ccs_pkg::CMD_FAN: fan_next = vh_reg;
                                ccs_pkg::CMD_RED: begin
                                    red_next = vh_reg;
                                    led_chg  = 1'b1;
                                end
                                ccs_pkg::CMD_GREEN: begin
                                    green_next = vh_reg;
                                    led_chg    = 1'b1;
                                end
                                ccs_pkg::CMD_BLUE: begin
                                    blue_next = vh_reg;
                                    led_chg   = 1'b1;
                                end
                                default: err_inc = 1'b1;
                            endcase
                        end else begin
                            err_inc = 1'b1;
                        end
                        pos_next = pos_reg + 8'h01;
                    end
                    if (cmd_next == ccs_pkg::CMD_BUZZER && vh_next == ccs_pkg::VAL_CLICK) begin
                        click = 1'b1;
                        pin_next[ccs_pkg::PIN_BUZZER] = 1'b0;
                    end
                end
                ccs_pkg::KIND_RD: begin
                    if ((cmd_reg >= ccs_pkg::CMD_RELAY1 && cmd_reg <= ccs_pkg::CMD_BLUE)
                        || cmd_reg == ccs_pkg::CMD_BACKLIGHT) begin
                        // write command read back: crc, then poisoned
                        tx       = crc_reg;
                        crc_next = 8'hFF;
                    end else begin
                        known = 1'b1;
                        if (ccs_pkg::meas_slot_ok(cmd_reg)) begin
                            last = 2'd2;
                            d    = (pos_reg == 8'h00) ? latch_reg[7:0] : latch_reg[15:8];
                        end else if (cmd_reg == ccs_pkg::CMD_RD_RGB) begin
                            last = 2'd3;
                            case (pos_reg)
                                8'h00:   d = red_reg;
                                8'h01:   d = green_reg;
                                8'h02:   d = blue_reg;
                                default: d = 8'h00;
                            endcase
                        end else if (cmd_reg == ccs_pkg::CMD_RD_BL) begin
                            last = 2'd1;
                            d    = rd_data[7:0];
                        end else if (cmd_reg >= ccs_pkg::CMD_RD_PIN1
                                     && cmd_reg <= ccs_pkg::CMD_RD_PIN6) begin
                            last = 2'd1;
                            d    = pin_reg[3'(cmd_reg - ccs_pkg::CMD_RD_PIN1)] ? 8'hFF : 8'h00;
                        end else if (cmd_reg == ccs_pkg::CMD_RD_FAN) begin
                            last = 2'd1;
                            d    = fan_reg;
                        end else begin
                            known = 1'b0;
                        end
                        if (!known) begin
                            tx = ccs_pkg::BYTE_NONE;
                        end else if (pos_reg < {6'd0, last}) begin
                            crc_next = ccs_pkg::crc_step(crc_reg, d);
                            tx       = d;
                        end else if (pos_reg == {6'd0, last}) begin
                            tx = crc_reg;
                        end else begin
                            // overrun
                            err_inc = 1'b1;
                            tx      = ccs_pkg::BYTE_NONE;
                        end
                    end
                    pos_next = pos_reg + 8'h01;
                end
                ccs_pkg::KIND_MEAS: begin
                    // store write happens at acceptance
                end
                default: begin
                end
            endcase
            if (err_inc && err_reg != ccs_pkg::ERR_MAX) begin
                err_next = err_reg + 8'h01;
            end
        end

        res_next.tx_byte          = tx;
        res_next.tx_valid         = (in_item.kind == ccs_pkg::KIND_RD);
        res_next.pin_states       = pin_next;
        res_next.fan_duty         = fan_next;
        res_next.led_red          = red_next;
        res_next.led_green        = green_next;
        res_next.led_blue         = blue_next;
        res_next.backlight_target = bl_next;
        res_next.led_changed      = led_chg;
        res_next.buzzer_click     = click;
        res_next.error_count      = err_next;

        if (in_take) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= 8'hFF;
            pos_reg   <= ccs_pkg::NO_POS;
            crc_reg   <= 8'h00;
            vh_reg    <= 8'h00;
            latch_reg <= 16'h0000;
            pin_reg   <= 6'd0;
            fan_reg   <= ccs_pkg::FAN_RESET;
            red_reg   <= 8'h00;
            green_reg <= 8'h00;
            blue_reg  <= 8'h00;
            bl_reg    <= ccs_pkg::BL_RESET;
            err_reg   <= 8'h00;
            valid_reg <= 1'b0;
        end else begin
            cmd_reg   <= cmd_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            vh_reg    <= vh_next;
            latch_reg <= latch_next;
            pin_reg   <= pin_next;
            fan_reg   <= fan_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            bl_reg    <= bl_next;
            err_reg   <= err_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    `CCS_ASSERT_NEXT(a_err_no_drop, aclk, aresetn, !(in_take && cmd_start), err_reg >= $past(err_reg))
    `CCS_ASSERT_NEXT(a_click_is_buzzer, aclk, aresetn, in_take && res_next.buzzer_click, cmd_reg == ccs_pkg::CMD_BUZZER)
    `CCS_ASSERT_NEXT(a_tx_valid_kind, aclk, aresetn, in_take, res_reg.tx_valid == ($past(in_item.kind) == ccs_pkg::KIND_RD))

endmodule
